>>> sv/wbgc_pkg.sv
package wbgc_pkg;

  localparam int STAMP_BITS = 16;
  localparam int FIELD_BITS = 16;
  localparam int TIME_BITS = 32;

  localparam int IN_TDATA_BITS = 40;
  localparam int OUT_TDATA_BITS = 40;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WATCH,
    PH_WINDOW
  } phase_t;

  localparam logic [2:0] V_NOT_PRESSED = 3'd0;
  localparam logic [2:0] V_SHORT = 3'd1;
  localparam logic [2:0] V_LONG = 3'd2;
  localparam logic [2:0] V_DOUBLE = 3'd3;
  localparam logic [2:0] V_EARLY = 3'd4;
  localparam logic [2:0] V_NO_SECOND = 3'd5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_ALLOWED = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_HOLD_EN = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_CLICK_EN = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REQUIRED_HOLD = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOUNCE = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DOUBLE_WINDOW = 3'd5;

  localparam logic [15:0] RST_REQUIRED_HOLD = 16'd1000;
  localparam logic [15:0] RST_BOUNCE = 16'd100;
  localparam logic [15:0] RST_DOUBLE_WINDOW = 16'd300;

  typedef struct packed {
    logic        short_allowed;
    logic        long_hold_enabled;
    logic        double_click_enabled;
    logic [15:0] required_hold_ms;
    logic [15:0] bounce_ms;
    logic [15:0] click_window_ms;
  } cfg_t;

  typedef struct packed {
    logic                 action;
    logic [TIME_BITS-1:0] now_ms;
    logic                 button_down;
  } item_t;

  typedef struct packed {
    logic [2:0]            verdict;
    logic [FIELD_BITS-1:0] end_stamp;
    logic [FIELD_BITS-1:0] held_ms;
  } res_t;

  function automatic logic [STAMP_BITS-1:0] sat_stamp(input logic [TIME_BITS-1:0] v);
    logic [TIME_BITS-1:0] lim;
    lim = TIME_BITS'((64'd1 << STAMP_BITS) - 64'd1);
    return (v > lim) ? STAMP_BITS'(lim) : STAMP_BITS'(v);
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(input logic [STAMP_BITS-1:0] s);
    return FIELD_BITS'(TIME_BITS'(s));
  endfunction

endpackage

>>> sv/wbgc_core.sv
module wbgc_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  wbgc_pkg::item_t item,
  input  wbgc_pkg::cfg_t  cfg,
  output logic           res_valid,
  output wbgc_pkg::res_t  res
);

  wbgc_pkg::phase_t phase_r, phase_nxt;
  logic [wbgc_pkg::TIME_BITS-1:0]  gate_r, gate_nxt;
  logic [wbgc_pkg::TIME_BITS-1:0]  last_r, last_nxt;
  logic [wbgc_pkg::TIME_BITS-1:0]  rel_r, rel_nxt;
  logic [wbgc_pkg::STAMP_BITS-1:0] held_r, held_nxt;

  logic [wbgc_pkg::TIME_BITS-1:0]  now;
  logic [wbgc_pkg::TIME_BITS-1:0]  gate_eff;
  logic [wbgc_pkg::TIME_BITS-1:0]  since_rel;
  logic [wbgc_pkg::TIME_BITS-1:0]  since_last;
  logic [wbgc_pkg::STAMP_BITS-1:0] held_rel;
  logic [wbgc_pkg::STAMP_BITS-1:0] held_long;
  logic                            watch;

  assign now        = item.now_ms;
  assign gate_eff   = item.action ? gate_r : now;
  assign since_rel  = now - rel_r;
  assign since_last = now - last_r;
  assign held_rel   = wbgc_pkg::sat_stamp(last_r - gate_eff);
  assign held_long  = wbgc_pkg::sat_stamp(now - gate_eff);

  always_comb begin
    phase_nxt     = phase_r;
    gate_nxt      = gate_r;
    last_nxt      = last_r;
    rel_nxt       = rel_r;
    held_nxt      = held_r;
    res_valid     = 1'b0;
    res.verdict   = wbgc_pkg::V_NOT_PRESSED;
    res.end_stamp = wbgc_pkg::to_field(wbgc_pkg::sat_stamp(now));
    res.held_ms   = '0;
    watch         = 1'b0;
    if (fire) begin
      if (!item.action) begin
        gate_nxt  = now;
        phase_nxt = wbgc_pkg::PH_IDLE;
        if (!item.button_down) begin
          res_valid = 1'b1;
        end else if (cfg.short_allowed) begin
          res_valid   = 1'b1;
          res.verdict = wbgc_pkg::V_SHORT;
        end else begin
          phase_nxt = wbgc_pkg::PH_WATCH;
          watch     = 1'b1;
        end
      end else if (phase_r == wbgc_pkg::PH_WINDOW) begin
        if (since_rel >= {16'd0, cfg.click_window_ms}) begin
          res_valid   = 1'b1;
          res.verdict = wbgc_pkg::V_NO_SECOND;
          res.held_ms = wbgc_pkg::to_field(held_r);
        end else if (item.button_down) begin
          res_valid   = 1'b1;
          res.verdict = wbgc_pkg::V_DOUBLE;
          res.held_ms = wbgc_pkg::to_field(held_r);
        end
      end else if (phase_r == wbgc_pkg::PH_WATCH) begin
        watch = 1'b1;
      end

      if (watch) begin
        if (item.button_down) begin
          last_nxt = now;
          if (cfg.long_hold_enabled && now >= {16'd0, cfg.required_hold_ms}) begin
            res_valid   = 1'b1;
            res.verdict = wbgc_pkg::V_LONG;
            res.held_ms = wbgc_pkg::to_field(held_long);
          end
        end else if (since_last >= {16'd0, cfg.bounce_ms}) begin
          if (!cfg.double_click_enabled) begin
            res_valid   = 1'b1;
            res.verdict = wbgc_pkg::V_EARLY;
            res.held_ms = wbgc_pkg::to_field(held_rel);
          end else begin
            held_nxt  = held_rel;
            rel_nxt   = now;
            phase_nxt = wbgc_pkg::PH_WINDOW;
          end
        end
      end

      if (res_valid) begin
        phase_nxt = wbgc_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wbgc_pkg::PH_IDLE;
      gate_r  <= '0;
      last_r  <= '0;
      rel_r   <= '0;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      gate_r  <= gate_nxt;
      last_r  <= last_nxt;
      rel_r   <= rel_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

>>> sv/wake_button_gesture_classifier.sv
// out_tvalid rises once the input transfer has passed the input register, then
// the result register.
// Throughput: one button sample per cycle; the gesture state updates as each advances.
// A held result stalls the input only once the input register is full as well.
// Reset: synchronous, active-low rst_n empties both registers, returns the
// gesture state to idle and loads the registers' reset values.
module wake_button_gesture_classifier (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] now_ms, [32] button_down, [39:33] zero
  input  logic [wbgc_pkg::IN_TDATA_BITS-1:0]  in_tdata,
  // [0] action
  input  logic [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] verdict, [18:3] end_stamp, [34:19] held_ms, [39:35] zero
  output logic [wbgc_pkg::OUT_TDATA_BITS-1:0] out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wbgc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wbgc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  wbgc_pkg::cfg_t  cfg_r;
  wbgc_pkg::item_t item_r;
  wbgc_pkg::res_t  res, res_r;
  logic            item_valid_r;
  logic            out_valid_r;
  logic            advance;
  logic            res_valid;

  assign cfg_ready  = 1'b1;
  assign advance    = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !item_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, res_r.held_ms, res_r.end_stamp, res_r.verdict};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_allowed        <= 1'b0;
      cfg_r.long_hold_enabled    <= 1'b1;
      cfg_r.double_click_enabled <= 1'b0;
      cfg_r.required_hold_ms     <= wbgc_pkg::RST_REQUIRED_HOLD;
      cfg_r.bounce_ms            <= wbgc_pkg::RST_BOUNCE;
      cfg_r.click_window_ms      <= wbgc_pkg::RST_DOUBLE_WINDOW;
    end else if (cfg_valid) begin
      case (cfg_index)
        wbgc_pkg::REG_SHORT_ALLOWED:   cfg_r.short_allowed <= cfg_data[0];
        wbgc_pkg::REG_LONG_HOLD_EN:    cfg_r.long_hold_enabled <= cfg_data[0];
        wbgc_pkg::REG_DOUBLE_CLICK_EN: cfg_r.double_click_enabled <= cfg_data[0];
        wbgc_pkg::REG_REQUIRED_HOLD:   cfg_r.required_hold_ms <= cfg_data;
        wbgc_pkg::REG_BOUNCE:          cfg_r.bounce_ms <= cfg_data;
        wbgc_pkg::REG_DOUBLE_WINDOW:   cfg_r.click_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.action      <= in_tuser[0];
      item_r.now_ms      <= in_tdata[31:0];
      item_r.button_down <= in_tdata[32];
    end
  end

  wbgc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (item_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule
